// File: hdl/law_pkg.sv
// shared types and constants for the lattice aggregation walker step block
// no dependencies; compiled first

package law_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_GRID_SIDE    = 256;
  localparam int DEF_WALKER_COUNT = 1024;

  // cells probed around a walker, plus its own cell
  localparam int NEIGHBOURS = 8;
  localparam int STAMP_W    = 24;

  // command codes
  typedef enum logic [1:0] {
    CMD_PLACE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // step direction codes
  typedef enum logic [2:0] {
    DIR_XP   = 3'd0,
    DIR_XM   = 3'd1,
    DIR_YP   = 3'd2,
    DIR_YM   = 3'd3,
    DIR_XPYP = 3'd4,
    DIR_XPYM = 3'd5,
    DIR_XMYP = 3'd6,
    DIR_XMYM = 3'd7
  } dir_e;

  // input word
  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         walker_index;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
    logic [2:0]         direction;
    logic [STAMP_W-1:0] stamp;
  } item_t;

  // result word
  typedef struct packed {
    logic [7:0]         walker_x;
    logic [7:0]         walker_y;
    logic               walker_active;
    logic               stuck;
    logic [STAMP_W-1:0] cell_value;
  } result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic resolve;
    logic probe;
    logic finish;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pending;
    logic pipe_busy;
  } stat_t;

endpackage

// File: hdl/law_ctrl.sv
// controller state machine for the lattice aggregation walker step block
// depends on law_pkg (ctl_t, stat_t)

module law_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  law_pkg::stat_t stat_i,
  output law_pkg::ctl_t  ctl_o,
  output logic          busy_o
);
  import law_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_PROBE = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_en = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        ctl_o.resolve = 1'b1;
        state_d       = S_PROBE;
      end
      S_PROBE: begin
        ctl_o.probe = 1'b1;
        if (!stat_i.pending && !stat_i.pipe_busy) state_d = S_FIN;
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // state register, clearing pass runs after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: hdl/law_dpath.sv
// datapath for the lattice aggregation walker step block: walker table,
// grid memory, neighbour probe pipeline, result register
// depends on law_pkg (item_t, result_t, ctl_t, stat_t, codes)

module law_dpath #(
  parameter int GRID_SIDE    = law_pkg::DEF_GRID_SIDE,
  parameter int WALKER_COUNT = law_pkg::DEF_WALKER_COUNT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  law_pkg::item_t   item_i,
  input  law_pkg::ctl_t    ctl_i,
  output law_pkg::stat_t   stat_o,
  output logic             done_o,
  output law_pkg::result_t result_o
);
  import law_pkg::*;

  localparam int XW         = $clog2(GRID_SIDE);
  localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int WW         = (WALKER_COUNT > 1) ? $clog2(WALKER_COUNT) : 1;
  localparam int EW         = 2 * XW + 1;
  localparam int CLR_DEPTH  = (GRID_DEPTH > WALKER_COUNT) ? GRID_DEPTH : WALKER_COUNT;
  localparam int CW         = $clog2(CLR_DEPTH + 1);
  localparam int RW         = 20;
  localparam logic [AW-1:0] CENTRE_ADDR = AW'((GRID_SIDE / 2) * GRID_SIDE + GRID_SIDE / 2);
  localparam logic [XW-1:0] SIDE_MAX    = XW'(GRID_SIDE - 1);
  localparam logic [3:0]    PROBES      = 4'(NEIGHBOURS + 1);

  // reduce an 8-bit coordinate modulo the grid side by shifted subtracts
  function automatic logic [XW-1:0] reduce_coord(input logic [7:0] v);
    logic [RW-1:0] r;
    r = RW'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (RW'(GRID_SIDE) << k)) r = r - (RW'(GRID_SIDE) << k);
    end
    return XW'(r);
  endfunction

  function automatic logic [XW-1:0] wrap_inc(input logic [XW-1:0] v);
    return (v == SIDE_MAX) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [XW-1:0] wrap_dec(input logic [XW-1:0] v);
    return (v == '0) ? SIDE_MAX : v - 1'b1;
  endfunction

  function automatic logic [AW-1:0] grid_addr(input logic [XW-1:0] x,
                                              input logic [XW-1:0] y);
    return AW'(AW'(x) * AW'(GRID_SIDE)) + AW'(y);
  endfunction

  // captured command word
  logic [1:0]         cmd_q;
  logic               idx_ok_q;
  logic [WW-1:0]      widx_q;
  logic [XW-1:0]      px_q, py_q;
  logic [2:0]         dir_q;
  logic [STAMP_W-1:0] stamp_q;

  // walker table read data
  logic [EW-1:0] wrd_q;
  logic [XW-1:0] wk_x, wk_y;
  logic          wk_act;

  // resolved walker state
  logic [XW-1:0] cx_q, cy_q, cx_d, cy_d;
  logic [3:0]    nprobe_q, nprobe_d, cnt_q;
  logic          mover_q, mover_d, rep_q, rep_d, act_q, act_d;

  // probe pipeline
  logic [XW-1:0]      xm, xp, ym, yp, prb_x, prb_y;
  logic               issue;
  logic [AW-1:0]      addr_a_q, own_addr_q;
  logic               vld_a_q, tag0_a_q, vld_r_q, tag0_r_q;
  logic [STAMP_W-1:0] grd_q, own_q;
  logic               nb_any_q;
  logic               stuck;

  // clearing pass
  logic [CW-1:0] clr_q;

  // memories and write ports
  logic [STAMP_W-1:0] gmem [GRID_DEPTH];
  logic [EW-1:0]      wmem [WALKER_COUNT];
  logic               gwe, wwe;
  logic [AW-1:0]      gwaddr;
  logic [STAMP_W-1:0] gwdata;
  logic [WW-1:0]      wwaddr;
  logic [EW-1:0]      wwdata;

  result_t res_d, res_q;
  logic    done_q;

  assign {wk_x, wk_y, wk_act} = wrd_q;

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= item_i.command;
      idx_ok_q <= (32'(item_i.walker_index) < 32'(WALKER_COUNT));
      widx_q   <= WW'(item_i.walker_index);
      px_q     <= reduce_coord(item_i.pos_x);
      py_q     <= reduce_coord(item_i.pos_y);
      dir_q    <= item_i.direction;
      stamp_q  <= item_i.stamp;
    end
  end

  // decide the centre cell and how many cells to probe
  always_comb begin
    cx_d     = px_q;
    cy_d     = py_q;
    nprobe_d = 4'd1;
    mover_d  = 1'b0;
    rep_d    = 1'b0;
    act_d    = 1'b0;
    case (cmd_q)
      CMD_READ: begin
        nprobe_d = 4'd1;
      end
      CMD_PLACE: begin
        if (idx_ok_q) begin
          rep_d = 1'b1;
          act_d = 1'b1;
        end else begin
          nprobe_d = '0;
        end
      end
      CMD_STEP: begin
        if (!idx_ok_q) begin
          nprobe_d = '0;
        end else begin
          rep_d = 1'b1;
          cx_d  = wk_x;
          cy_d  = wk_y;
          if (wk_act) begin
            mover_d  = 1'b1;
            act_d    = 1'b1;
            nprobe_d = PROBES;
            case (dir_q)
              DIR_XP:   cx_d = wrap_inc(wk_x);
              DIR_XM:   cx_d = wrap_dec(wk_x);
              DIR_YP:   cy_d = wrap_inc(wk_y);
              DIR_YM:   cy_d = wrap_dec(wk_y);
              DIR_XPYP: begin
                cx_d = wrap_inc(wk_x);
                cy_d = wrap_inc(wk_y);
              end
              DIR_XPYM: begin
                cx_d = wrap_inc(wk_x);
                cy_d = wrap_dec(wk_y);
              end
              DIR_XMYP: begin
                cx_d = wrap_dec(wk_x);
                cy_d = wrap_inc(wk_y);
              end
              default: begin
                cx_d = wrap_dec(wk_x);
                cy_d = wrap_dec(wk_y);
              end
            endcase
          end
        end
      end
      default: nprobe_d = '0;
    endcase
  end

  // probe address select: own cell first, then the eight neighbours
  always_comb begin
    xm = wrap_dec(cx_q);
    xp = wrap_inc(cx_q);
    ym = wrap_dec(cy_q);
    yp = wrap_inc(cy_q);
    case (cnt_q)
      4'd0: begin prb_x = cx_q; prb_y = cy_q; end
      4'd1: begin prb_x = xm;   prb_y = ym;   end
      4'd2: begin prb_x = cx_q; prb_y = ym;   end
      4'd3: begin prb_x = xp;   prb_y = ym;   end
      4'd4: begin prb_x = xm;   prb_y = cy_q; end
      4'd5: begin prb_x = xp;   prb_y = cy_q; end
      4'd6: begin prb_x = xm;   prb_y = yp;   end
      4'd7: begin prb_x = cx_q; prb_y = yp;   end
      default: begin prb_x = xp; prb_y = yp;  end
    endcase
  end

  assign issue = ctl_i.probe && (cnt_q != nprobe_q);
  assign stuck = mover_q & nb_any_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      nprobe_q <= '0;
      vld_a_q  <= 1'b0;
      vld_r_q  <= 1'b0;
      clr_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      if (ctl_i.resolve) begin
        cnt_q    <= '0;
        nprobe_q <= nprobe_d;
      end else if (issue) begin
        cnt_q <= cnt_q + 4'd1;
      end
      vld_a_q <= issue;
      vld_r_q <= vld_a_q;
      if (ctl_i.clr_en) clr_q <= clr_q + 1'b1;
      done_q <= ctl_i.finish;
    end
  end

  // walker state, probe pipeline and accumulation
  always_ff @(posedge clk_i) begin
    if (ctl_i.resolve) begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      mover_q  <= mover_d;
      rep_q    <= rep_d;
      act_q    <= act_d;
      nb_any_q <= 1'b0;
    end
    if (issue) begin
      addr_a_q <= grid_addr(prb_x, prb_y);
      tag0_a_q <= (cnt_q == '0);
    end
    tag0_r_q <= tag0_a_q;
    if (vld_a_q && tag0_a_q) own_addr_q <= addr_a_q;
    if (vld_r_q) begin
      if (tag0_r_q) begin
        own_q <= grd_q;
      end else begin
        nb_any_q <= nb_any_q | (grd_q != '0);
      end
    end
    if (ctl_i.finish) res_q <= res_d;
  end

  // grid write: clearing pass with the seed at the centre, or a sticking walker
  always_comb begin
    gwe    = 1'b0;
    gwaddr = own_addr_q;
    gwdata = stamp_q;
    if (ctl_i.clr_en) begin
      gwe    = (clr_q < CW'(GRID_DEPTH));
      gwaddr = clr_q[AW-1:0];
      gwdata = (clr_q[AW-1:0] == CENTRE_ADDR) ? STAMP_W'(1) : '0;
    end else if (ctl_i.finish && stuck) begin
      gwe = 1'b1;
    end
  end

  // walker table write: clearing pass, place, or step of a free walker
  always_comb begin
    wwe    = 1'b0;
    wwaddr = widx_q;
    wwdata = {cx_q, cy_q, act_q & ~stuck};
    if (ctl_i.clr_en) begin
      wwe    = (clr_q < CW'(WALKER_COUNT));
      wwaddr = clr_q[WW-1:0];
      wwdata = '0;
    end else if (ctl_i.finish && rep_q && ((cmd_q == CMD_PLACE) || mover_q)) begin
      wwe = 1'b1;
    end
  end

  // grid memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (gwe) gmem[gwaddr] <= gwdata;
    if (vld_a_q) grd_q <= gmem[addr_a_q];
  end

  // walker table memory, read at accept
  always_ff @(posedge clk_i) begin
    if (wwe) wmem[wwaddr] <= wwdata;
    if (ctl_i.load) wrd_q <= wmem[WW'(item_i.walker_index)];
  end

  // result word
  always_comb begin
    res_d = '0;
    if (rep_q) begin
      res_d.walker_x      = 8'(cx_q);
      res_d.walker_y      = 8'(cy_q);
      res_d.walker_active = act_q & ~stuck;
      res_d.stuck         = stuck;
      res_d.cell_value    = stuck ? stamp_q : own_q;
    end else if (cmd_q == CMD_READ) begin
      res_d.cell_value = own_q;
    end
  end

  assign stat_o.clr_last  = (clr_q == CW'(CLR_DEPTH - 1));
  assign stat_o.pending   = (cnt_q != nprobe_q);
  assign stat_o.pipe_busy = vld_a_q | vld_r_q;
  assign done_o           = done_q;
  assign result_o         = res_q;

endmodule

// File: hdl/lattice_aggregation_walker_step.sv
// top level of the lattice aggregation walker step block
// depends on law_pkg, law_ctrl, law_dpath
//
//   channel   ports                 handshake
//   --------  --------------------  ------------------------------------
//   command   item_i, start, busy   word taken when start high, busy low
//   result    result_o, done_o      word valid for the one cycle done_o
//
// After reset a clearing pass runs over all GRID_SIDE*GRID_SIDE grid cells and
// all WALKER_COUNT walker table entries, zeroing the grid, seeding the centre cell and
// emptying the walker table; busy stays high during it.
// done_o pulses once the grid reads for the word are through: nine through the
// single grid memory port for a step of a free walker, one for place, read and a
// step of a stuck walker, none for an ignored command. A new word can be taken
// in the cycle done_o is high.
// The receiver cannot stall; each result is offered once.

module lattice_aggregation_walker_step #(
  parameter int GRID_SIDE    = law_pkg::DEF_GRID_SIDE,
  parameter int WALKER_COUNT = law_pkg::DEF_WALKER_COUNT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  law_pkg::item_t   item_i,
  output logic             done_o,
  output law_pkg::result_t result_o
);
  import law_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencer
  law_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  // storage and probe datapath
  law_dpath #(
    .GRID_SIDE    (GRID_SIDE),
    .WALKER_COUNT (WALKER_COUNT)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // a result shows only once the block is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // at most one datapath command at a time
  a_ctl_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.clr_en, ctl.load, ctl.resolve, ctl.probe, ctl.finish}))
    else $error("overlapping datapath commands");

  // grid reads in flight only while a word is being worked on
  a_pipe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pipe_busy |-> busy)
    else $error("grid probe in flight while idle");

endmodule

// File: test/lattice_aggregation_walker_step_tb.sv
// self-checking bench for lattice_aggregation_walker_step: walk, stick and read on the lattice
// depends on law_pkg and the lattice_aggregation_walker_step rtl
`timescale 1ns / 100ps

module lattice_aggregation_walker_step_tb;

  localparam int          SIDE           = law_pkg::DEF_GRID_SIDE;
  localparam int          WALKERS        = law_pkg::DEF_WALKER_COUNT;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          CENTRE         = SIDE / 2;
  localparam logic [23:0] STAMP_MAX      = 24'hFFFFFF;
  // the clearing pass after reset moves no words and so counts as quiet time
  localparam int          WATCHDOG_LIMIT = 250000;
  localparam int          DRAIN_CYCLES   = 20;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start  = 1'b0;
  logic             busy;
  law_pkg::item_t   item_i = '0;
  logic             done_o;
  law_pkg::result_t result_o;

  // stimulus and scoreboard state
  law_pkg::item_t   command_words[$];
  law_pkg::result_t predicted_words[$];
  law_pkg::result_t oldest_word;
  int               send_idle_pct = 0;
  int               error_count   = 0;
  int               quiet_cycles  = 0;

  // lattice model: cell stamps and walker table
  logic [23:0] grid_model[0:SIDE-1][0:SIDE-1];
  logic [7:0]  walker_x_model[0:WALKERS-1];
  logic [7:0]  walker_y_model[0:WALKERS-1];
  logic        walker_free_model[0:WALKERS-1];

  lattice_aggregation_walker_step u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #6 clk_i = ~clk_i;

  // empty lattice with the seed in the centre, every walker parked and inactive
  task automatic clear_lattice();
    for (int i = 0; i < SIDE; i++) begin
      for (int j = 0; j < SIDE; j++) begin
        grid_model[i][j] = '0;
      end
    end
    for (int k = 0; k < WALKERS; k++) begin
      walker_x_model[k]    = '0;
      walker_y_model[k]    = '0;
      walker_free_model[k] = 1'b0;
    end
    grid_model[CENTRE][CENTRE] = 24'd1;
  endtask

  // applies one word to the lattice model and returns the word the block must give back
  function automatic law_pkg::result_t predict_lattice(law_pkg::item_t it);
    law_pkg::result_t res;
    logic [7:0]       wx, wy;
    logic             touches;
    int               k;
    res     = '0;
    touches = 1'b0;
    k       = int'(it.walker_index);
    if (it.command == law_pkg::CMD_READ) begin
      res.cell_value = grid_model[it.pos_x][it.pos_y];
      return res;
    end
    if (it.command == CMD_UNUSED || k >= WALKERS) return res;
    if (it.command == law_pkg::CMD_PLACE) begin
      walker_x_model[k]    = it.pos_x;
      walker_y_model[k]    = it.pos_y;
      walker_free_model[k] = 1'b1;
    end else if (walker_free_model[k]) begin
      wx = walker_x_model[k];
      wy = walker_y_model[k];
      // 8-bit arithmetic wraps around the torus
      case (law_pkg::dir_e'(it.direction))
        law_pkg::DIR_XP:   wx = wx + 8'd1;
        law_pkg::DIR_XM:   wx = wx - 8'd1;
        law_pkg::DIR_YP:   wy = wy + 8'd1;
        law_pkg::DIR_YM:   wy = wy - 8'd1;
        law_pkg::DIR_XPYP: begin wx = wx + 8'd1; wy = wy + 8'd1; end
        law_pkg::DIR_XPYM: begin wx = wx + 8'd1; wy = wy - 8'd1; end
        law_pkg::DIR_XMYP: begin wx = wx - 8'd1; wy = wy + 8'd1; end
        default:           begin wx = wx - 8'd1; wy = wy - 8'd1; end
      endcase
      walker_x_model[k] = wx;
      walker_y_model[k] = wy;
      // any occupied cell among the eight around the new position
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          if ((dx != 0 || dy != 0) && grid_model[8'(wx + 8'(dx))][8'(wy + 8'(dy))] != '0)
            touches = 1'b1;
        end
      end
      if (touches) begin
        grid_model[wx][wy]   = it.stamp;
        walker_free_model[k] = 1'b0;
        res.stuck            = 1'b1;
      end
    end
    res.walker_x      = walker_x_model[k];
    res.walker_y      = walker_y_model[k];
    res.walker_active = walker_free_model[k];
    res.cell_value    = grid_model[walker_x_model[k]][walker_y_model[k]];
    return res;
  endfunction

  task automatic add_word(logic [1:0] cmd, int idx, int x, int y, int dir, logic [23:0] stmp);
    law_pkg::item_t it;
    it.command      = cmd;
    it.walker_index = 10'(idx);
    it.pos_x        = 8'(x);
    it.pos_y        = 8'(y);
    it.direction    = 3'(dir);
    it.stamp        = stmp;
    command_words.push_back(it);
  endtask

  // mostly ordinary stamps, with zero and the largest value now and then
  function automatic logic [23:0] pick_stamp();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return STAMP_MAX;
    return 24'($urandom_range(1, 24'hFFFFFF));
  endfunction

  // directed words: extremes, every direction with wrap, sticking, stuck walker, unused command
  task automatic add_directed();
    add_word(law_pkg::CMD_READ, 0, CENTRE, CENTRE, 0, 24'd0);
    add_word(law_pkg::CMD_READ, 0, 0, 0, 0, 24'd0);
    add_word(law_pkg::CMD_READ, 1023, 255, 255, 7, STAMP_MAX);
    // a walker that was never placed reports the parked entry
    add_word(law_pkg::CMD_STEP, 5, 0, 0, law_pkg::DIR_XP, 24'd9);
    // diagonal step next to the seed sticks with the largest stamp
    add_word(law_pkg::CMD_PLACE, 0, CENTRE + 2, CENTRE + 2, 0, 24'd0);
    add_word(law_pkg::CMD_STEP, 0, 0, 0, law_pkg::DIR_XMYM, STAMP_MAX);
    add_word(law_pkg::CMD_STEP, 0, 0, 0, law_pkg::DIR_XP, 24'd3);
    add_word(law_pkg::CMD_READ, 0, CENTRE + 1, CENTRE + 1, 0, 24'd0);
    // stamp of zero sticks but leaves the cell empty
    add_word(law_pkg::CMD_PLACE, 1023, CENTRE - 2, CENTRE, 0, 24'd0);
    add_word(law_pkg::CMD_STEP, 1023, 0, 0, law_pkg::DIR_XP, 24'd0);
    add_word(law_pkg::CMD_READ, 0, CENTRE - 1, CENTRE, 0, 24'd0);
    // every direction, crossing both edges in both axes
    add_word(law_pkg::CMD_PLACE, 512, 0, 0, 0, 24'd0);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XM, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_YM, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XPYP, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XMYM, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XPYM, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XMYP, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_YP, 24'd5);
    add_word(law_pkg::CMD_STEP, 512, 0, 0, law_pkg::DIR_XP, 24'd5);
    // unused command gives an all-zero word
    add_word(CMD_UNUSED, 0, 0, 0, 0, 24'd0);
    add_word(CMD_UNUSED, 1023, 255, 255, 7, STAMP_MAX);
    add_word(law_pkg::CMD_PLACE, 341, 255, 255, 0, STAMP_MAX);
    add_word(law_pkg::CMD_PLACE, 682, 8'hAA, 8'h55, 0, 24'd0);
  endtask

  // random words, mostly walks launched close to the aggregate so that many stick
  task automatic add_random(int count);
    int target, r, idx, steps;
    target = command_words.size() + count;
    while (command_words.size() < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        idx   = $urandom_range(WALKERS - 1);
        steps = $urandom_range(1, 16);
        add_word(law_pkg::CMD_PLACE, idx, CENTRE - 8 + $urandom_range(16),
                 CENTRE - 8 + $urandom_range(16), $urandom_range(7), pick_stamp());
        for (int s = 0; s < steps; s++)
          add_word(law_pkg::CMD_STEP, idx, $urandom_range(255), $urandom_range(255),
                   $urandom_range(7), pick_stamp());
      end else if (r < 70) begin
        add_word(law_pkg::CMD_READ, $urandom_range(WALKERS - 1),
                 CENTRE - 10 + $urandom_range(20), CENTRE - 10 + $urandom_range(20),
                 $urandom_range(7), pick_stamp());
      end else if (r < 80) begin
        add_word(law_pkg::CMD_READ, $urandom_range(WALKERS - 1), $urandom_range(255),
                 $urandom_range(255), $urandom_range(7), pick_stamp());
      end else if (r < 92) begin
        add_word(law_pkg::CMD_STEP, $urandom_range(WALKERS - 1), $urandom_range(255),
                 $urandom_range(255), $urandom_range(7), pick_stamp());
      end else if (r < 96) begin
        add_word(law_pkg::CMD_PLACE, $urandom_range(WALKERS - 1), $urandom_range(255),
                 $urandom_range(255), $urandom_range(7), pick_stamp());
      end else begin
        add_word(CMD_UNUSED, $urandom_range(WALKERS - 1), $urandom_range(255),
                 $urandom_range(255), $urandom_range(7), pick_stamp());
      end
    end
  endtask

  // holds until every word has been taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (command_words.size() != 0 || start || predicted_words.size() != 0);
  endtask

  // driver: word taken when start is high and busy is low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy == 1'b0)
        predicted_words.push_back(predict_lattice(item_i));
      if (!start || busy == 1'b0) begin
        if (command_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          start  <= 1'b1;
          item_i <= command_words.pop_front();
        end else begin
          start  <= 1'b0;
        end
      end
    end
  end

  // monitor: each done pulse is checked against the oldest prediction
  task automatic report_field(string name, logic [23:0] want, logic [23:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (predicted_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, result_o);
        error_count++;
      end else begin
        oldest_word = predicted_words.pop_front();
        if (result_o.walker_x !== oldest_word.walker_x)
          report_field("walker_x", oldest_word.walker_x, result_o.walker_x);
        if (result_o.walker_y !== oldest_word.walker_y)
          report_field("walker_y", oldest_word.walker_y, result_o.walker_y);
        if (result_o.walker_active !== oldest_word.walker_active)
          report_field("walker_active", oldest_word.walker_active, result_o.walker_active);
        if (result_o.stuck !== oldest_word.stuck)
          report_field("stuck", oldest_word.stuck, result_o.stuck);
        if (result_o.cell_value !== oldest_word.cell_value)
          report_field("cell_value", oldest_word.cell_value, result_o.cell_value);
      end
    end
  end

  // watchdog: cycles in which neither a command nor a result word moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy == 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** lattice_aggregation_walker_step: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // phases of sender idling, each one drained before the next
  initial begin
    clear_lattice();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    add_directed();
    add_random(180);
    wait_drained();
    send_idle_pct = 85;
    add_random(140);
    wait_drained();
    send_idle_pct = 25;
    add_random(140);
    wait_drained();
    send_idle_pct = 0;
    add_random(70);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("** lattice_aggregation_walker_step: PASSED **");
    end else begin
      $display("** lattice_aggregation_walker_step: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/law_pkg.sv
hdl/law_ctrl.sv
hdl/law_dpath.sv
hdl/lattice_aggregation_walker_step.sv
test/lattice_aggregation_walker_step_tb.sv
